// File: sv/iwg_pkg.sv
// Shared types, constants and fixed-point helpers of the interpolation weight generator.
package iwg_pkg;

    localparam int MAX_RADIUS  = 1023;
    localparam int WEIGHT_FRAC = 30;
    localparam int T_FRAC      = 24;

    localparam int TAP_W    = 11;
    localparam int EXP_W    = 6;
    localparam int WEIGHT_W = 32;
    localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int TQ_W     = T_FRAC + 3;
    localparam int Q_W      = T_FRAC + 4;
    localparam int MAG_W    = 32;
    localparam int VAL_W    = 36;

    localparam int DIV3_SH  = 30;
    localparam int DIV3_W   = DIV3_SH - 1;
    localparam longint DIV3_MUL = ((longint'(1) << DIV3_SH) + 2) / 3;

    localparam int WF_UP     = (WEIGHT_FRAC >= T_FRAC) ? WEIGHT_FRAC - T_FRAC : 0;
    localparam int WF_DN     = (WEIGHT_FRAC >= T_FRAC) ? 0 : T_FRAC - WEIGHT_FRAC;
    localparam int WF_DN_RND = (WF_DN > 0) ? WF_DN - 1 : 0;

    localparam longint UNIT    = longint'(1) << T_FRAC;
    localparam longint SAT_LIM = longint'(1) << (TQ_W - 1);

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t ONE   = val_t'(longint'(1) << WEIGHT_FRAC);
    localparam val_t TWO   = val_t'(longint'(2) << WEIGHT_FRAC);
    localparam val_t THREE = val_t'(longint'(3) << WEIGHT_FRAC);
    localparam val_t FOUR  = val_t'(longint'(4) << WEIGHT_FRAC);

    localparam val_t C_3_2  = val_t'(((longint'(3) << WEIGHT_FRAC) + 1) / 2);
    localparam val_t C_1_2  = val_t'(((longint'(1) << WEIGHT_FRAC) + 1) / 2);
    localparam val_t C_1_4  = val_t'(((longint'(1) << WEIGHT_FRAC) + 2) / 4);
    localparam val_t C_5_12 = val_t'(((longint'(5) << WEIGHT_FRAC) + 6) / 12);
    localparam val_t C_1_6  = val_t'(((longint'(1) << WEIGHT_FRAC) + 3) / 6);
    localparam val_t C_3_8  = val_t'(((longint'(3) << WEIGHT_FRAC) + 4) / 8);
    localparam val_t C_5_24 = val_t'(((longint'(5) << WEIGHT_FRAC) + 12) / 24);
    localparam val_t C_1_24 = val_t'(((longint'(1) << WEIGHT_FRAC) + 12) / 24);

    typedef enum logic [1:0] {
        MODE_UNSET,
        MODE_CUBIC,
        MODE_QUINTIC,
        MODE_QUINTIC_C2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE,
        CFG_EXPONENT,
        CFG_TRIPLE
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PC_NONE,
        PC_CUB1,
        PC_CUB2,
        PC_QUI1,
        PC_QUI2,
        PC_QUI3
    } piece_t;

    typedef struct packed {
        mode_t                   mode;
        logic signed [EXP_W-1:0] exponent;
        logic                    triple;
    } cfg_t;

    typedef struct packed {
        piece_t          piece;
        logic [TQ_W-1:0] tq;
        logic            bad;
    } scl_item_t;

    function automatic val_t to_wf(input logic [TQ_W-1:0] tq);
        logic [VAL_W-1:0] wide;
        wide = VAL_W'(tq);
        if (WF_DN == 0) begin
            return val_t'(wide << WF_UP);
        end
        return val_t'((wide + (VAL_W'(1) << WF_DN_RND)) >> WF_DN);
    endfunction

    // Sign-magnitude product, rounded to nearest with ties away from zero.
    function automatic val_t fmul(input val_t a, input val_t b);
        logic [MAG_W-1:0]   ua;
        logic [MAG_W-1:0]   ub;
        logic [2*MAG_W-1:0] p;
        logic [2*MAG_W-1:0] r;
        logic               neg;
        neg = a[VAL_W-1] ^ b[VAL_W-1];
        ua  = a[VAL_W-1] ? MAG_W'(-a) : MAG_W'(a);
        ub  = b[VAL_W-1] ? MAG_W'(-b) : MAG_W'(b);
        p   = (2*MAG_W)'(ua) * (2*MAG_W)'(ub);
        r   = (p + ((2*MAG_W)'(1) << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC;
        return neg ? -val_t'(r) : val_t'(r);
    endfunction

endpackage

// File: sv/interp_weight_generator.sv
// Top level of the interpolation weight generator: configuration registers and pipeline.
//
// Each request on the s_ channel carries one signed tap offset; the m_ channel
// returns one weight (signed, 30 fraction bits) and a bad-mode flag per request,
// in order. Both channels use valid/ready.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// register 0 interp_mode, 1 scale_exponent, 2 scale_triple; other indexes are
// ignored. cfg_ready is always high. Write configuration only while no request
// is in flight.
// There are seven register stages: two scaling stages and five multiply stages,
// the depth set by the five chained products of the outer quintic piece. m_valid
// rises once a request has passed all seven registers. Throughput is one request
// per cycle while the receiver does not stall.
// Reset selects cubic mode, exponent 0, no factor three, and empties the pipeline.
// When the receiver stalls, results hold in place, empty stages still fill, and
// s_ready drops only once all seven stages hold a request.
module interp_weight_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [iwg_pkg::TAP_W-1:0]    s_tap_offset,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [iwg_pkg::WEIGHT_W-1:0] m_weight,
    output logic                                m_bad_mode,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [iwg_pkg::EXP_W-1:0]           cfg_data
);
    import iwg_pkg::*;

    mode_t                   mode_reg;
    logic signed [EXP_W-1:0] exp_reg;
    logic                    triple_reg;
    cfg_t                    cfg;
    logic                    scl_valid;
    logic                    scl_ready;
    scl_item_t               scl_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_CUBIC;
            exp_reg    <= '0;
            triple_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:     mode_reg   <= mode_t'(cfg_data[1:0]);
                CFG_EXPONENT: exp_reg    <= cfg_data;
                CFG_TRIPLE:   triple_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.exponent = exp_reg;
    assign cfg.triple   = triple_reg;

    iwg_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_tap    (s_tap_offset),
        .cfg       (cfg),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_item  (scl_item)
    );

    iwg_poly u_poly (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (scl_valid),
        .in_ready   (scl_ready),
        .in_item    (scl_item),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_weight (m_weight),
        .out_bad    (m_bad_mode)
    );

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input refused while the output is not stalled");

endmodule

// File: sv/iwg_scale.sv
// Two-stage scaling of the tap offset to t with 24 fraction bits and basis piece selection.
module iwg_scale (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [iwg_pkg::TAP_W-1:0]   in_tap,
    input  iwg_pkg::cfg_t                      cfg,
    output logic                               out_valid,
    input  logic                               out_ready,
    output iwg_pkg::scl_item_t                 out_item
);
    import iwg_pkg::*;

    localparam int SH_W      = EXP_W + 2;
    localparam int AMT_W     = 6;
    localparam int SH_SAT    = T_FRAC + 3;
    localparam int PRE_SH    = 8;
    localparam int N_W       = RAD_W + SH_SAT + PRE_SH;
    localparam int QF_W      = N_W - PRE_SH;
    localparam int PROD_W    = Q_W + DIV3_W;
    localparam int HALF_1    = 128;
    localparam int HALF_3    = 384;
    localparam longint SAT3_LIM = 3 * SAT_LIM + 2;

    logic [TAP_W-1:0]       mag;
    logic [RAD_W-1:0]       a;
    logic signed [SH_W-1:0] sh;
    logic                   sh_sat;
    logic [AMT_W-1:0]       amt;
    logic [N_W-1:0]         n_rnd;
    logic [QF_W-1:0]        q;
    logic                   over;

    logic                   v1_reg;
    logic [Q_W-1:0]         qc_reg, qc_next;
    logic                   sat_reg, sat_next;
    logic                   triple_reg;
    mode_t                  mode_reg;

    logic [PROD_W-1:0]      prod;
    logic [TQ_W-1:0]        tq;
    scl_item_t              item_next;
    logic                   v2_reg;
    scl_item_t              item_reg;

    logic                   en1, en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        mag    = in_tap[TAP_W-1] ? (~in_tap + 1'b1) : in_tap;
        a      = (mag > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(mag);
        sh     = SH_W'(T_FRAC) - SH_W'(cfg.exponent);
        sh_sat = (sh >= SH_W'(SH_SAT));
        amt    = AMT_W'(sh + SH_W'(PRE_SH));
        n_rnd  = (N_W'(a) << amt) + (cfg.triple ? N_W'(HALF_3) : N_W'(HALF_1));
        q      = n_rnd[N_W-1:PRE_SH];
        over   = cfg.triple ? (q > QF_W'(SAT3_LIM)) : (q > QF_W'(SAT_LIM));
        sat_next = (a != '0) && (sh_sat || over);
        qc_next  = q[Q_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= in_valid;
        end
        if (en1) begin
            qc_reg     <= qc_next;
            sat_reg    <= sat_next;
            triple_reg <= cfg.triple;
            mode_reg   <= cfg.mode;
        end
    end

    always_comb begin
        prod = PROD_W'(qc_reg) * PROD_W'(DIV3_MUL);
        if (sat_reg) begin
            tq = TQ_W'(SAT_LIM);
        end else if (triple_reg) begin
            tq = prod[DIV3_SH +: TQ_W];
        end else begin
            tq = qc_reg[TQ_W-1:0];
        end
        item_next.tq    = tq;
        item_next.bad   = (mode_reg != MODE_CUBIC) && (mode_reg != MODE_QUINTIC);
        item_next.piece = PC_NONE;
        unique case (mode_reg)
            MODE_CUBIC: begin
                if (tq <= TQ_W'(UNIT)) begin
                    item_next.piece = PC_CUB1;
                end else if (tq <= TQ_W'(2 * UNIT)) begin
                    item_next.piece = PC_CUB2;
                end
            end
            MODE_QUINTIC: begin
                if (tq <= TQ_W'(UNIT)) begin
                    item_next.piece = PC_QUI1;
                end else if (tq <= TQ_W'(2 * UNIT)) begin
                    item_next.piece = PC_QUI2;
                end else if (tq <= TQ_W'(3 * UNIT)) begin
                    item_next.piece = PC_QUI3;
                end
            end
            default: begin
                item_next.piece = PC_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
        if (en2) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

    a_tq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_item.tq <= TQ_W'(SAT_LIM)))
        else $error("scaled t exceeds saturation value");

    a_bad_no_piece: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_item.bad) |-> (out_item.piece == PC_NONE))
        else $error("bad mode selected a basis piece");

endmodule

// File: sv/iwg_poly.sv
// Five-stage multiply pipeline that evaluates the selected cubic or quintic basis piece.
module iwg_poly (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  iwg_pkg::scl_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [iwg_pkg::WEIGHT_W-1:0] out_weight,
    output logic                                out_bad
);
    import iwg_pkg::*;

    localparam int NST = 5;

    typedef struct packed {
        piece_t          piece;
        logic [TQ_W-1:0] tq;
        val_t            l;
        val_t            r;
        logic            bad;
    } pstage_t;

    pstage_t st_reg  [NST];
    pstage_t st_next [NST];
    logic    vld_reg [NST];
    logic    en      [NST];

    val_t t0, t1, t2, t3, t4;
    val_t la0, lb0, ra0, rb0;
    val_t la1, lb1, ra1, rb1;
    val_t a2, b2, a3, b3, a4, b4;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_comb begin
        t0 = to_wf(in_item.tq);
        unique case (in_item.piece)
            PC_CUB1: begin
                la0 = ONE - t0;  lb0 = ONE;       ra0 = t0;       rb0 = t0;
            end
            PC_CUB2: begin
                la0 = C_1_2;     lb0 = ONE - t0;  ra0 = TWO - t0; rb0 = TWO - t0;
            end
            PC_QUI1: begin
                la0 = t0;        lb0 = t0;        ra0 = C_5_12;   rb0 = t0;
            end
            PC_QUI2: begin
                la0 = ONE - t0;  lb0 = TWO - t0;  ra0 = C_5_24;   rb0 = t0;
            end
            PC_QUI3: begin
                la0 = C_1_24;    lb0 = ONE - t0;  ra0 = '0;       rb0 = '0;
            end
            default: begin
                la0 = '0;        lb0 = '0;        ra0 = '0;       rb0 = '0;
            end
        endcase
        st_next[0].piece = in_item.piece;
        st_next[0].tq    = in_item.tq;
        st_next[0].bad   = in_item.bad;
        st_next[0].l     = fmul(la0, lb0);
        st_next[0].r     = fmul(ra0, rb0);
    end

    always_comb begin
        t1 = to_wf(st_reg[0].tq);
        unique case (st_reg[0].piece)
            PC_CUB1: begin
                la1 = st_reg[0].l;        lb1 = ONE;
                ra1 = C_3_2;              rb1 = st_reg[0].r;
            end
            PC_CUB2: begin
                la1 = st_reg[0].l;        lb1 = ONE;
                ra1 = st_reg[0].r;        rb1 = ONE;
            end
            PC_QUI1: begin
                la1 = ONE - st_reg[0].l;  lb1 = TWO - t1;
                ra1 = t1;                 rb1 = C_1_4 - st_reg[0].r;
            end
            PC_QUI2: begin
                la1 = st_reg[0].l;        lb1 = THREE - t1;
                ra1 = t1;                 rb1 = C_3_8 - st_reg[0].r;
            end
            PC_QUI3: begin
                la1 = st_reg[0].l;        lb1 = TWO - t1;
                ra1 = st_reg[0].r;        rb1 = ONE;
            end
            default: begin
                la1 = '0;                 lb1 = '0;
                ra1 = '0;                 rb1 = '0;
            end
        endcase
        st_next[1]   = st_reg[0];
        st_next[1].l = fmul(la1, lb1);
        st_next[1].r = fmul(ra1, rb1);
    end

    always_comb begin
        t2 = to_wf(st_reg[1].tq);
        unique case (st_reg[1].piece)
            PC_CUB1: begin
                a2 = st_reg[1].l;  b2 = (ONE + t2) - st_reg[1].r;
            end
            PC_CUB2: begin
                a2 = st_reg[1].l;  b2 = st_reg[1].r;
            end
            PC_QUI1: begin
                a2 = st_reg[1].l;  b2 = C_1_2 + st_reg[1].r;
            end
            PC_QUI2: begin
                a2 = st_reg[1].l;  b2 = C_1_6 + st_reg[1].r;
            end
            PC_QUI3: begin
                a2 = st_reg[1].l;  b2 = THREE - t2;
            end
            default: begin
                a2 = '0;           b2 = '0;
            end
        endcase
        st_next[2]   = st_reg[1];
        st_next[2].l = fmul(a2, b2);
    end

    always_comb begin
        t3 = to_wf(st_reg[2].tq);
        a3 = st_reg[2].l;
        b3 = (st_reg[2].piece == PC_QUI3) ? (THREE - t3) : ONE;
        st_next[3]   = st_reg[2];
        st_next[3].l = fmul(a3, b3);
    end

    always_comb begin
        t4 = to_wf(st_reg[3].tq);
        a4 = st_reg[3].l;
        b4 = (st_reg[3].piece == PC_QUI3) ? (FOUR - t4) : ONE;
        st_next[4]   = st_reg[3];
        st_next[4].l = fmul(a4, b4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign out_weight = st_reg[NST-1].l[WEIGHT_W-1:0];
    assign out_bad    = st_reg[NST-1].bad;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_bad) |-> (out_weight == '0))
        else $error("bad mode request carries a nonzero weight");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_valid)
        else $error("pipeline holds a result after reset");

endmodule
